>>> sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> sv/fsce_pkg.sv
// Types, constants and character tables of the format character emitter.
`timescale 1ns / 1ps
package fsce_pkg;

    localparam logic [1:0] FUNC_FMT = 2'd0;
    localparam logic [1:0] FUNC_INT = 2'd1;
    localparam logic [1:0] FUNC_STR = 2'd2;
    localparam logic [1:0] FUNC_END = 2'd3;

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_S     = 8'h73;

    localparam int COUNT_W = 31;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam int ARG_W    = 32;
    localparam int DIGITS   = 10;
    localparam int BCD_W    = 4 * DIGITS;
    localparam int BITCNT_W = $clog2(ARG_W);
    localparam logic [BITCNT_W-1:0] CONV_LAST = BITCNT_W'(ARG_W - 1);
    localparam int NULL_LEN = 6;
    localparam logic [2:0] NULL_LAST = 3'(NULL_LEN - 1);

    typedef enum logic [1:0] {
        AW_NONE = 2'd0,
        AW_DEC  = 2'd1,
        AW_HEX  = 2'd2,
        AW_STR  = 2'd3
    } awaited_t;

    typedef enum logic [2:0] {
        SEL_PCT,
        SEL_BYTE,
        SEL_MINUS,
        SEL_DIGIT,
        SEL_NULL,
        SEL_DONE,
        SEL_ERR
    } emit_sel_t;

    typedef struct packed {
        logic      capture;
        logic      load_dec;
        logic      load_hex;
        logic      dabble;
        logic      load_idx;
        logic      load_ptr;
        logic      emit;
        emit_sel_t sel;
        logic      last;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       is_pct;
        logic       is_d;
        logic       is_x;
        logic       is_s;
        logic       str_end;
        logic       str_null;
        logic       neg;
        logic       conv_last;
        logic       digit_last;
        logic       null_last;
        logic       slot_free;
    } dp_sts_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        case (nib)
            4'h0: c = 8'h30;
            4'h1: c = 8'h31;
            4'h2: c = 8'h32;
            4'h3: c = 8'h33;
            4'h4: c = 8'h34;
            4'h5: c = 8'h35;
            4'h6: c = 8'h36;
            4'h7: c = 8'h37;
            4'h8: c = 8'h38;
            4'h9: c = 8'h39;
            4'ha: c = 8'h61;
            4'hb: c = 8'h62;
            4'hc: c = 8'h63;
            4'hd: c = 8'h64;
            4'he: c = 8'h65;
            default: c = 8'h66;
        endcase
        return c;
    endfunction

    // "(null)"
    function automatic logic [7:0] null_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0: c = 8'h28;
            3'd1: c = 8'h6e;
            3'd2: c = 8'h75;
            3'd3: c = 8'h6c;
            3'd4: c = 8'h6c;
            default: c = 8'h29;
        endcase
        return c;
    endfunction

endpackage

>>> sv/fsce_dp.sv
// Datapath: item capture, binary to BCD conversion, character select, count, result register.
`timescale 1ns / 1ps
module fsce_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fsce_pkg::dp_cmd_t           cmd,
    output fsce_pkg::dp_sts_t           sts,
    input  logic [1:0]                  func,
    input  logic [7:0]                  data_byte,
    input  logic [31:0]                 arg_value,
    input  logic                        str_end,
    input  logic                        str_null,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  out_char,
    output logic                        char_valid,
    output logic [fsce_pkg::COUNT_W-1:0] char_count,
    output logic                        is_last,
    output logic                        format_done,
    output logic                        error
);
    import fsce_pkg::*;

    logic [1:0]          func_reg;
    logic [7:0]          byte_reg;
    logic [ARG_W-1:0]    arg_reg;
    logic                end_reg;
    logic                null_reg;
    logic                neg_reg;
    logic [BCD_W-1:0]    bcd_reg;
    logic [BITCNT_W-1:0] bit_cnt_reg;
    logic [3:0]          idx_reg;
    logic [2:0]          ptr_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic                out_valid_reg;
    logic [7:0]          out_char_reg;
    logic                char_valid_reg;
    logic [COUNT_W-1:0]  char_count_reg;
    logic                is_last_reg;
    logic                done_reg;
    logic                error_reg;

    logic [ARG_W-1:0]   mag;
    logic [BCD_W-1:0]   bcd_adj;
    logic [3:0]         lead_idx;
    logic [3:0]         cur_digit;
    logic [7:0]         char_next;
    logic               is_char;
    logic [COUNT_W-1:0] count_inc;

    always_comb
    begin
        mag = arg_reg[ARG_W-1] ? (ARG_W'(0) - arg_reg) : arg_reg;
    end

    // add 3 to every BCD digit of five or more before the shift
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            else
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
        end
    end

    // highest nonzero digit, zero if all digits are zero
    always_comb
    begin
        lead_idx = '0;
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] != 4'd0)
                lead_idx = 4'(i);
        end
    end

    assign cur_digit = bcd_reg[idx_reg*4 +: 4];
    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;

    always_comb
    begin
        char_next = 8'h00;
        is_char   = 1'b1;
        case (cmd.sel)
            SEL_PCT:   char_next = CH_PCT;
            SEL_BYTE:  char_next = byte_reg;
            SEL_MINUS: char_next = CH_MINUS;
            SEL_DIGIT: char_next = hex_char(cur_digit);
            SEL_NULL:  char_next = null_char(ptr_reg);
            default:   is_char   = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= func;
            byte_reg <= data_byte;
            arg_reg  <= arg_value;
            end_reg  <= str_end;
            null_reg <= str_null;
        end
        else if (cmd.load_dec)
        begin
            arg_reg <= mag;
        end
        else if (cmd.dabble)
        begin
            arg_reg <= {arg_reg[ARG_W-2:0], 1'b0};
        end

        if (cmd.load_dec)
        begin
            neg_reg     <= arg_reg[ARG_W-1];
            bcd_reg     <= '0;
            bit_cnt_reg <= '0;
        end
        else if (cmd.load_hex)
        begin
            neg_reg <= 1'b0;
            bcd_reg <= {{(BCD_W-ARG_W){1'b0}}, arg_reg};
        end
        else if (cmd.dabble)
        begin
            bcd_reg     <= {bcd_adj[BCD_W-2:0], arg_reg[ARG_W-1]};
            bit_cnt_reg <= bit_cnt_reg + 1'b1;
        end

        if (cmd.load_idx)
            idx_reg <= lead_idx;
        else if (cmd.emit && cmd.sel == SEL_DIGIT)
            idx_reg <= idx_reg - 1'b1;

        if (cmd.load_ptr)
            ptr_reg <= '0;
        else if (cmd.emit && cmd.sel == SEL_NULL)
            ptr_reg <= ptr_reg + 1'b1;

        if (cmd.emit)
        begin
            out_char_reg   <= char_next;
            char_valid_reg <= is_char;
            char_count_reg <= is_char ? count_inc : count_reg;
            is_last_reg    <= cmd.last;
            done_reg       <= (cmd.sel == SEL_DONE);
            error_reg      <= (cmd.sel == SEL_ERR);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (cmd.emit && cmd.sel == SEL_DONE)
                count_reg <= '0;
            else if (cmd.emit && is_char)
                count_reg <= count_inc;
        end
    end

    always_comb
    begin
        sts.func       = func_reg;
        sts.is_pct     = (byte_reg == CH_PCT);
        sts.is_d       = (byte_reg == CH_D);
        sts.is_x       = (byte_reg == CH_X);
        sts.is_s       = (byte_reg == CH_S);
        sts.str_end    = end_reg;
        sts.str_null   = null_reg;
        sts.neg        = neg_reg;
        sts.conv_last  = (bit_cnt_reg == CONV_LAST);
        sts.digit_last = (idx_reg == 4'd0);
        sts.null_last  = (ptr_reg == NULL_LAST);
        sts.slot_free  = !out_valid_reg || out_ready;
    end

    assign out_valid   = out_valid_reg;
    assign out_char    = out_char_reg;
    assign char_valid  = char_valid_reg;
    assign char_count  = char_count_reg;
    assign is_last     = is_last_reg;
    assign format_done = done_reg;
    assign error       = error_reg;

endmodule

>>> sv/fsce_ctrl.sv
// Controller: percent and argument tracking, sequencing of result words.
`timescale 1ns / 1ps
module fsce_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  fsce_pkg::dp_sts_t sts,
    output fsce_pkg::dp_cmd_t cmd
);
    import fsce_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b00000000001,
        ST_DECODE = 11'b00000000010,
        ST_PCT    = 11'b00000000100,
        ST_BYTE   = 11'b00000001000,
        ST_CONV   = 11'b00000010000,
        ST_LEAD   = 11'b00000100000,
        ST_SIGN   = 11'b00001000000,
        ST_DIGIT  = 11'b00010000000,
        ST_NULLS  = 11'b00100000000,
        ST_DONE   = 11'b01000000000,
        ST_ERR    = 11'b10000000000
    } state_t;

    state_t   state_reg, state_next;
    logic     pp_reg, pp_next;
    awaited_t aw_reg, aw_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pp_reg    <= 1'b0;
            aw_reg    <= AW_NONE;
        end
        else
        begin
            state_reg <= state_next;
            pp_reg    <= pp_next;
            aw_reg    <= aw_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.sel    = SEL_ERR;
        state_next = state_reg;
        pp_next    = pp_reg;
        aw_next    = aw_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (sts.func)
                    FUNC_FMT:
                    begin
                        if (aw_reg != AW_NONE)
                            state_next = ST_ERR;
                        else if (pp_reg)
                        begin
                            if (sts.is_d || sts.is_x || sts.is_s)
                            begin
                                pp_next    = 1'b0;
                                state_next = ST_IDLE;
                                if (sts.is_d)
                                    aw_next = AW_DEC;
                                else if (sts.is_x)
                                    aw_next = AW_HEX;
                                else
                                    aw_next = AW_STR;
                            end
                            else
                            begin
                                // a second percent stays held
                                pp_next    = sts.is_pct;
                                state_next = ST_PCT;
                            end
                        end
                        else if (sts.is_pct)
                        begin
                            pp_next    = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                            state_next = ST_BYTE;
                    end
                    FUNC_INT:
                    begin
                        if (aw_reg == AW_DEC)
                        begin
                            cmd.load_dec = 1'b1;
                            aw_next      = AW_NONE;
                            state_next   = ST_CONV;
                        end
                        else if (aw_reg == AW_HEX)
                        begin
                            cmd.load_hex = 1'b1;
                            aw_next      = AW_NONE;
                            state_next   = ST_LEAD;
                        end
                        else
                            state_next = ST_ERR;
                    end
                    FUNC_STR:
                    begin
                        if (aw_reg != AW_STR)
                            state_next = ST_ERR;
                        else if (sts.str_null)
                        begin
                            cmd.load_ptr = 1'b1;
                            aw_next      = AW_NONE;
                            state_next   = ST_NULLS;
                        end
                        else if (sts.str_end)
                        begin
                            aw_next    = AW_NONE;
                            state_next = ST_IDLE;
                        end
                        else
                            state_next = ST_BYTE;
                    end
                    default:
                    begin
                        pp_next    = 1'b0;
                        aw_next    = AW_NONE;
                        state_next = pp_reg ? ST_PCT : ST_DONE;
                    end
                endcase
            end
            ST_PCT:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.sel  = SEL_PCT;
                    cmd.last = (sts.func == FUNC_FMT) && sts.is_pct;
                    if (sts.func == FUNC_END)
                        state_next = ST_DONE;
                    else if (sts.is_pct)
                        state_next = ST_IDLE;
                    else
                        state_next = ST_BYTE;
                end
            end
            ST_BYTE:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = SEL_BYTE;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_CONV:
            begin
                cmd.dabble = 1'b1;
                if (sts.conv_last)
                    state_next = ST_LEAD;
            end
            ST_LEAD:
            begin
                cmd.load_idx = 1'b1;
                state_next   = sts.neg ? ST_SIGN : ST_DIGIT;
            end
            ST_SIGN:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = SEL_MINUS;
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.sel  = SEL_DIGIT;
                    cmd.last = sts.digit_last;
                    if (sts.digit_last)
                        state_next = ST_IDLE;
                end
            end
            ST_NULLS:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.sel  = SEL_NULL;
                    cmd.last = sts.null_last;
                    if (sts.null_last)
                        state_next = ST_IDLE;
                end
            end
            ST_DONE:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = SEL_DONE;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_ERR:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = SEL_ERR;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

>>> sv/format_string_char_emitter.sv
// Top level of the %s/%d/%x format character emitter.
// A word is decoded the cycle after acceptance; its first result word is registered once
// an emitting state finds the output free, then one result word per cycle unless stalled.
// A new word is taken only once the last one is finished; a hex argument adds a leading-digit
// step, a decimal argument also its 32-step bit-serial BCD conversion.
// Reset (rst_n, async low) clears the percent flag, awaited argument, count and result valid.
`timescale 1ns / 1ps
module format_string_char_emitter (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   func,
    input  logic [7:0]                   data_byte,
    input  logic signed [31:0]           arg_value,
    input  logic                         str_end,
    input  logic                         str_null,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [7:0]                   out_char,
    output logic                         char_valid,
    output logic [fsce_pkg::COUNT_W-1:0] char_count,
    output logic                         is_last,
    output logic                         format_done,
    output logic                         error
);
    import fsce_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    fsce_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fsce_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .func        (func),
        .data_byte   (data_byte),
        .arg_value   (arg_value),
        .str_end     (str_end),
        .str_null    (str_null),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_char    (out_char),
        .char_valid  (char_valid),
        .char_count  (char_count),
        .is_last     (is_last),
        .format_done (format_done),
        .error       (error)
    );

endmodule

>>> sv/fsce_checker.sv
// Port-level checks of the format character emitter, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fsce_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [7:0]                   out_char,
    input logic                         char_valid,
    input logic [fsce_pkg::COUNT_W-1:0] char_count,
    input logic                         is_last,
    input logic                         format_done,
    input logic                         error
);
    import fsce_pkg::*;

    // one word at a time: input closes right after an accept
    `ASSERT_NEXT(a_in_single, in_valid && in_ready, !in_ready)
    // a stalled word keeps its character and count
    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_char) && $stable(char_count))
    // the done word closes its item and carries no character
    `ASSERT_SAME(a_done_last, out_valid && format_done, is_last && !char_valid && !error && out_char == 8'h00)
    // a dropped word stands alone and carries no character
    `ASSERT_SAME(a_err_alone, out_valid && error, is_last && !char_valid && out_char == 8'h00)
    // a character word is neither done nor error and has a nonzero count
    `ASSERT_SAME(a_char_count, out_valid && char_valid, !format_done && !error && char_count != '0)

endmodule

bind format_string_char_emitter fsce_checker u_fsce_checker (.*);

>>> bench/tb.sv
// Testbench for the format character emitter: directed and random formats checked in order.
`timescale 1ns / 1ps
module tb;
    import fsce_pkg::*;

    localparam int LONG_HOLD    = 200;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 40;
    localparam int WORD_TOTAL   = 350;

    localparam logic [7:0]   CH_ZERO    = "0";
    localparam logic [7:0]   CH_Q       = "q";
    localparam logic [7:0]   CH_H       = "h";
    localparam logic [7:0]   CH_OPEN    = "[";
    localparam logic [7:0]   CH_CLOSE   = "]";
    localparam logic [127:0] HEX_DIGITS = "0123456789abcdef";
    localparam logic [47:0]  NULL_TEXT  = "(null)";

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_THREE_IN_FOUR,
        RDY_SPARSE
    } ready_mode_t;

    typedef enum logic [2:0] {
        PIECE_TEXT,
        PIECE_PCT_PCT,
        PIECE_PCT_OTHER,
        PIECE_DEC,
        PIECE_HEX,
        PIECE_STR
    } piece_t;

    typedef struct packed {
        logic [7:0]         ch;
        logic               vld;
        logic [COUNT_W-1:0] cnt;
        logic               last;
        logic               done;
        logic               err;
    } emitted_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [1:0]          func;
    logic [7:0]          data_byte;
    logic signed [31:0]  arg_value;
    logic                str_end;
    logic                str_null;
    logic                out_valid;
    logic                out_ready;
    logic [7:0]          out_char;
    logic                char_valid;
    logic [COUNT_W-1:0]  char_count;
    logic                is_last;
    logic                format_done;
    logic                error;

    // Predictor state
    logic               pct_held;
    awaited_t           awaiting;
    logic [COUNT_W-1:0] fmt_count;
    emitted_t           staged;
    bit                 have_staged;
    emitted_t           expected_chars[$];

    int mismatches;
    int words_sent;
    int burst_left;
    int hold_requests;

    format_string_char_emitter DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .data_byte   (data_byte),
        .arg_value   (arg_value),
        .str_end     (str_end),
        .str_null    (str_null),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_char    (out_char),
        .char_valid  (char_valid),
        .char_count  (char_count),
        .is_last     (is_last),
        .format_done (format_done),
        .error       (error)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    task automatic stage_word(input logic [7:0] ch, input logic vld, input logic done,
                              input logic err);
        if (have_staged)
            expected_chars.push_back(staged);
        staged.ch   = ch;
        staged.vld  = vld;
        staged.cnt  = fmt_count;
        staged.last = 1'b0;
        staged.done = done;
        staged.err  = err;
        have_staged = 1'b1;
    endtask

    task automatic emit_char(input logic [7:0] ch);
        if (fmt_count != COUNT_MAX)
            fmt_count = fmt_count + 1'b1;
        stage_word(ch, 1'b1, 1'b0, 1'b0);
    endtask

    task automatic emit_decimal(input logic [31:0] raw);
        logic [31:0] mag;
        logic [7:0]  digs [0:9];
        int          len;
        mag = raw;
        len = 0;
        if (raw[31])
        begin
            emit_char(CH_MINUS);
            mag = -raw;
        end
        do
        begin
            digs[len] = CH_ZERO + 8'(mag % 10);
            mag = mag / 10;
            len++;
        end
        while (mag != 0 && len < 10);
        while (len > 0)
        begin
            len--;
            emit_char(digs[len]);
        end
    endtask

    task automatic emit_hex(input logic [31:0] raw);
        logic [31:0] v;
        logic [7:0]  digs [0:7];
        int          len;
        v = raw;
        len = 0;
        do
        begin
            digs[len] = HEX_DIGITS[8*(15 - int'(v[3:0])) +: 8];
            v = v >> 4;
            len++;
        end
        while (v != 0 && len < 8);
        while (len > 0)
        begin
            len--;
            emit_char(digs[len]);
        end
    endtask

    task automatic predict_emitted(input logic [1:0] f, input logic [7:0] b,
                                   input logic [31:0] a, input logic e, input logic n);
        have_staged = 1'b0;
        case (f)
            FUNC_FMT:
            begin
                if (awaiting != AW_NONE)
                    stage_word(8'h00, 1'b0, 1'b0, 1'b1);
                else
                begin
                    if (pct_held)
                    begin
                        pct_held = 1'b0;
                        if (b == CH_D)
                            awaiting = AW_DEC;
                        else if (b == CH_X)
                            awaiting = AW_HEX;
                        else if (b == CH_S)
                            awaiting = AW_STR;
                        else
                            emit_char(CH_PCT);
                    end
                    if (awaiting == AW_NONE)
                    begin
                        if (b == CH_PCT)
                            pct_held = 1'b1;
                        else
                            emit_char(b);
                    end
                end
            end
            FUNC_INT:
            begin
                if (awaiting == AW_DEC)
                begin
                    emit_decimal(a);
                    awaiting = AW_NONE;
                end
                else if (awaiting == AW_HEX)
                begin
                    emit_hex(a);
                    awaiting = AW_NONE;
                end
                else
                    stage_word(8'h00, 1'b0, 1'b0, 1'b1);
            end
            FUNC_STR:
            begin
                if (awaiting != AW_STR)
                    stage_word(8'h00, 1'b0, 1'b0, 1'b1);
                else if (n)
                begin
                    for (int i = 0; i < 6; i++)
                        emit_char(NULL_TEXT[8*(5 - i) +: 8]);
                    awaiting = AW_NONE;
                end
                else if (e)
                    awaiting = AW_NONE;
                else
                    emit_char(b);
            end
            default:
            begin
                if (pct_held)
                    emit_char(CH_PCT);
                stage_word(8'h00, 1'b0, 1'b1, 1'b0);
                pct_held  = 1'b0;
                awaiting  = AW_NONE;
                fmt_count = '0;
            end
        endcase
        if (have_staged)
        begin
            staged.last = 1'b1;
            expected_chars.push_back(staged);
        end
    endtask

    // ---------------------------------------------------------------- sender

    task automatic send_word(input logic [1:0] f, input logic [7:0] b, input logic [31:0] a,
                             input logic e, input logic n);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        in_valid  <= 1'b1;
        func      <= f;
        data_byte <= b;
        arg_value <= a;
        str_end   <= e;
        str_null  <= n;
        do
            @(posedge clk);
        while (!in_ready);
        predict_emitted(f, b, a, e, n);
        burst_left--;
        words_sent++;
    endtask

    task automatic send_fmt(input logic [7:0] b);
        send_word(FUNC_FMT, b, $urandom, 1'($urandom), 1'($urandom));
    endtask

    task automatic send_int(input logic [31:0] a);
        send_word(FUNC_INT, 8'($urandom), a, 1'($urandom), 1'($urandom));
    endtask

    task automatic send_str_char(input logic [7:0] c);
        send_word(FUNC_STR, c, $urandom, 1'b0, 1'b0);
    endtask

    task automatic send_str_term();
        send_word(FUNC_STR, 8'($urandom), $urandom, 1'b1, 1'b0);
    endtask

    task automatic send_str_null();
        send_word(FUNC_STR, 8'($urandom), $urandom, 1'($urandom), 1'b1);
    endtask

    task automatic send_end();
        send_word(FUNC_END, 8'($urandom), $urandom, 1'($urandom), 1'($urandom));
    endtask

    function automatic logic [31:0] pick_arg();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(0, 9);
            3: return -$urandom_range(1, 1000);
            default: return $urandom;
        endcase
    endfunction

    // ---------------------------------------------------------------- receiver

    initial
    begin : receiver
        ready_mode_t mode;
        int          mode_left;
        int          hold_left;
        int          hold_seen;
        int          phase;
        mode      = RDY_ALWAYS;
        mode_left = 0;
        hold_left = 0;
        hold_seen = 0;
        phase     = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_requests)
            begin
                hold_seen = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (mode_left == 0)
            begin
                mode      = ready_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(10, 80);
            end
            mode_left--;
            phase++;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    RDY_ALWAYS:        out_ready <= 1'b1;
                    RDY_COIN:          out_ready <= 1'($urandom);
                    RDY_THREE_IN_FOUR: out_ready <= (phase % 4) != 0;
                    default:           out_ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < 40)
            $display("%0t ns  %s: got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : check_results
        emitted_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_chars.size() == 0)
                report_mismatch("result with nothing expected", {24'h0, out_char}, 32'h0);
            else
            begin
                want = expected_chars.pop_front();
                if (out_char !== want.ch)
                    report_mismatch("out_char", 32'(out_char), 32'(want.ch));
                if (char_valid !== want.vld)
                    report_mismatch("char_valid", 32'(char_valid), 32'(want.vld));
                if (char_count !== want.cnt)
                    report_mismatch("char_count", 32'(char_count), 32'(want.cnt));
                if (is_last !== want.last)
                    report_mismatch("is_last", 32'(is_last), 32'(want.last));
                if (format_done !== want.done)
                    report_mismatch("format_done", 32'(format_done), 32'(want.done));
                if (error !== want.err)
                    report_mismatch("error", 32'(error), 32'(want.err));
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        int idle;
        if (!rst_n)
            idle = 0;
        else if ((in_valid && in_ready) || (out_valid && out_ready))
            idle = 0;
        else
        begin
            idle++;
            if (idle >= IDLE_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- tests

    task automatic test_plain_bytes();
        send_fmt(8'h00);
        send_fmt(8'hff);
        send_fmt(CH_PCT);
        send_fmt(CH_PCT);
        send_fmt(CH_Q);
        send_fmt(CH_PCT);
        send_end();
    endtask

    task automatic test_conversions_and_errors();
        send_fmt(CH_PCT);
        send_fmt(CH_D);
        send_str_char(CH_H);
        send_fmt(CH_Q);
        send_int(32'h8000_0000);
        send_fmt(CH_PCT);
        send_fmt(CH_X);
        send_int(32'hffff_ffff);
        send_fmt(CH_PCT);
        send_fmt(CH_S);
        send_str_char(CH_H);
        send_str_term();
        send_fmt(CH_PCT);
        send_fmt(CH_S);
        send_word(FUNC_STR, 8'($urandom), $urandom, 1'b1, 1'b1);
        send_int(32'h7fff_ffff);
        send_str_char(CH_H);
        send_fmt(CH_PCT);
        send_fmt(CH_D);
        send_end();
    endtask

    // Stall the output long enough that the block backs up into its input.
    task automatic test_output_backpressure();
        hold_requests++;
        send_fmt(CH_OPEN);
        repeat (3)
        begin
            send_fmt(CH_PCT);
            send_fmt(CH_D);
            send_int(32'h8000_0000);
        end
        send_fmt(CH_PCT);
        send_fmt(CH_X);
        send_int(32'hdead_beef);
        send_fmt(CH_CLOSE);
        send_end();
    endtask

    task automatic send_random_format();
        piece_t piece;
        int     kind;
        repeat ($urandom_range(1, 6))
        begin
            piece = piece_t'($urandom_range(0, 5));
            kind  = $urandom_range(0, 9);
            case (piece)
                PIECE_TEXT:
                    repeat ($urandom_range(1, 4)) send_fmt(8'($urandom));
                PIECE_PCT_PCT:
                begin
                    send_fmt(CH_PCT);
                    send_fmt(CH_PCT);
                end
                PIECE_PCT_OTHER:
                begin
                    send_fmt(CH_PCT);
                    send_fmt(8'($urandom));
                end
                PIECE_DEC, PIECE_HEX:
                begin
                    send_fmt(CH_PCT);
                    send_fmt(piece == PIECE_DEC ? CH_D : CH_X);
                    // broken forms: argument missing, or a string element first
                    if (kind == 1)
                        send_str_char(8'($urandom));
                    if (kind != 0)
                        send_int(pick_arg());
                end
                default:
                begin
                    send_fmt(CH_PCT);
                    send_fmt(CH_S);
                    if (kind == 1)
                        send_int(pick_arg());
                    if ($urandom_range(0, 4) == 0)
                        send_str_null();
                    else
                    begin
                        repeat ($urandom_range(0, 5)) send_str_char(8'($urandom));
                        if (kind != 0)
                            send_str_term();
                    end
                end
            endcase
        end
        send_end();
    endtask

    task automatic test_random_formats();
        while (words_sent < WORD_TOTAL)
        begin
            if ($urandom_range(0, 9) == 0)
                send_word(2'($urandom), 8'($urandom), $urandom, 1'($urandom), 1'($urandom));
            else
                send_random_format();
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        func          = FUNC_FMT;
        data_byte     = 8'h00;
        arg_value     = 32'sd0;
        str_end       = 1'b0;
        str_null      = 1'b0;
        pct_held      = 1'b0;
        awaiting      = AW_NONE;
        fmt_count     = '0;
        have_staged   = 1'b0;
        mismatches    = 0;
        words_sent    = 0;
        burst_left    = 0;
        hold_requests = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_plain_bytes();
        test_conversions_and_errors();
        test_output_backpressure();
        test_random_formats();

        in_valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
